### src/reflow_profile_sequencer_macros.svh
// Assertion helpers used by the checker file.
`ifndef REFLOW_PROFILE_SEQUENCER_MACROS_SVH
`define REFLOW_PROFILE_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define RPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/rps_pkg.sv
`timescale 1ns / 1ps

package rps_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DEG_W      = 10;
  localparam int ACC_W      = DEG_W + FRAC_BITS;
  localparam int SEC_W      = 12;
  localparam int SPS_W      = 7;
  localparam int DIVR_W     = SEC_W + SPS_W;
  localparam int CNT_W      = $clog2(ACC_W);
  localparam int TEMP_W     = 14;
  localparam int TI_W       = TEMP_W - 2;
  localparam int DIFF_W     = TI_W + 1;
  localparam int OP_W       = 2;
  localparam int PHASE_W    = 3;
  localparam int SETP_W     = 18;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [OP_W-1:0] OP_START  = 2'd0;
  localparam logic [OP_W-1:0] OP_STOP   = 2'd1;
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd2;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd3;

  localparam logic [PHASE_W-1:0] PH_RESET    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_PREHEAT  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SOAK     = 3'd2;
  localparam logic [PHASE_W-1:0] PH_RAMPUP   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_PEAK     = 3'd4;
  localparam logic [PHASE_W-1:0] PH_COOLDOWN = 3'd5;

  localparam logic [STATUS_W-1:0] ST_TRANSITION = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HANDLED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_HOT        = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RD_ERR     = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_PREHEAT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOAK     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOAK_SEC = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMPUP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_SEC = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPS      = 3'd6;

  localparam logic [DEG_W-1:0] RST_PREHEAT  = 10'd100;
  localparam logic [DEG_W-1:0] RST_SOAK     = 10'd150;
  localparam logic [SEC_W-1:0] RST_SOAK_SEC = 12'd120;
  localparam logic [DEG_W-1:0] RST_RAMPUP   = 10'd215;
  localparam logic [SEC_W-1:0] RST_PEAK_SEC = 12'd5;
  localparam logic [DEG_W-1:0] RST_COOLDOWN = 10'd35;
  localparam logic [SPS_W-1:0] RST_SPS      = 7'd1;

  typedef enum logic [1:0] {
    CS_IDLE = 2'b01,
    CS_DIV  = 2'b10
  } ctrl_state_t;

  typedef struct packed {
    logic step;
    logic div_start;
    logic div_step;
    logic div_last;
    logic load_out;
    logic load_skid;
    logic move_skid;
  } cmd_t;

  typedef struct packed {
    logic soak_entry;
  } sts_t;

endpackage

### src/rps_in_if.sv
`timescale 1ns / 1ps

interface rps_in_if;
  logic                             valid;
  logic                             ready;
  logic [rps_pkg::OP_W-1:0]         operation;
  logic signed [rps_pkg::TEMP_W-1:0] temperature;
  logic                             read_ok;

  modport source(output valid, operation, temperature, read_ok, input ready);
  modport sink(input valid, operation, temperature, read_ok, output ready);
endinterface

### src/rps_out_if.sv
`timescale 1ns / 1ps

interface rps_out_if;
  logic                           valid;
  logic                           ready;
  logic [rps_pkg::PHASE_W-1:0]    phase;
  logic [rps_pkg::SETP_W-1:0]     setpoint;
  logic                           heater_enable;
  logic [rps_pkg::STATUS_W-1:0]   status;

  modport source(output valid, phase, setpoint, heater_enable, status, input ready);
  modport sink(input valid, phase, setpoint, heater_enable, status, output ready);
endinterface

### src/rps_ctrl.sv
`timescale 1ns / 1ps

module rps_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_ready,
  output logic          out_valid,
  input  rps_pkg::sts_t sts,
  output rps_pkg::cmd_t cmd
);

  rps_pkg::ctrl_state_t          state_r, state_nxt;
  logic [rps_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          skid_valid_r, skid_valid_nxt;
  logic                          accept;
  logic                          out_fire;

  assign in_ready  = (state_r == rps_pkg::CS_IDLE) && !skid_valid_r;
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;

  always_comb begin
    cmd.step      = accept;
    cmd.div_start = accept && sts.soak_entry;
    cmd.div_step  = (state_r == rps_pkg::CS_DIV);
    cmd.div_last  = (state_r == rps_pkg::CS_DIV) && (cnt_r == '0);
    cmd.load_out  = accept && (!out_valid_r || out_fire);
    cmd.load_skid = accept && out_valid_r && !out_fire;
    cmd.move_skid = out_fire && skid_valid_r;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      rps_pkg::CS_IDLE: begin
        if (cmd.div_start) begin
          state_nxt = rps_pkg::CS_DIV;
          cnt_nxt   = rps_pkg::CNT_W'(rps_pkg::ACC_W - 1);
        end
      end
      rps_pkg::CS_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = rps_pkg::CS_IDLE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: begin
        state_nxt = rps_pkg::CS_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out || cmd.move_skid) begin
      out_valid_nxt = 1'b1;
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
    skid_valid_nxt = skid_valid_r;
    if (cmd.load_skid) begin
      skid_valid_nxt = 1'b1;
    end else if (cmd.move_skid) begin
      skid_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rps_pkg::CS_IDLE;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

endmodule

### src/rps_datapath.sv
`timescale 1ns / 1ps

module rps_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rps_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic [rps_pkg::OP_W-1:0]            in_operation,
  input  logic signed [rps_pkg::TEMP_W-1:0]   in_temperature,
  input  logic                                in_read_ok,
  input  rps_pkg::cmd_t                       cmd,
  output rps_pkg::sts_t                       sts,
  output logic [rps_pkg::PHASE_W-1:0]         out_phase,
  output logic [rps_pkg::SETP_W-1:0]          out_setpoint,
  output logic                                out_heater_enable,
  output logic [rps_pkg::STATUS_W-1:0]        out_status
);

  logic [rps_pkg::DEG_W-1:0]    preheat_r, soak_r, rampup_r, cooldown_r;
  logic [rps_pkg::SEC_W-1:0]    soak_sec_r, peak_sec_r;
  logic [rps_pkg::SPS_W-1:0]    sps_r;

  logic [rps_pkg::PHASE_W-1:0]  phase_r, phase_nxt;
  logic [rps_pkg::ACC_W-1:0]    acc_r, acc_nxt;
  logic [rps_pkg::ACC_W-1:0]    step_r, step_nxt;
  logic [rps_pkg::SEC_W-1:0]    secs_r, secs_nxt;
  logic [rps_pkg::STATUS_W-1:0] res_status;

  logic [rps_pkg::ACC_W-1:0]    quo_r, quo_nxt;
  logic [rps_pkg::DIVR_W-1:0]   rem_r, rem_nxt;
  logic [rps_pkg::DIVR_W-1:0]   divisor_r, divisor_nxt;
  logic [rps_pkg::DIVR_W:0]     trial;
  logic [rps_pkg::DIVR_W:0]     trial_diff;
  logic [rps_pkg::DIVR_W-1:0]   prod;
  logic [rps_pkg::DEG_W-1:0]    soak_diff;

  logic [rps_pkg::TI_W-1:0]     t_int;
  logic signed [rps_pkg::DIFF_W-1:0] t_ext;
  logic signed [rps_pkg::DIFF_W-1:0] cool_ext;
  logic signed [rps_pkg::DIFF_W-1:0] win_diff;
  logic [rps_pkg::DEG_W-1:0]    target;
  logic                         hot;
  logic                         in_win;
  logic [rps_pkg::ACC_W:0]      sum;

  logic [rps_pkg::PHASE_W-1:0]  out_phase_r, skid_phase_r;
  logic [rps_pkg::SETP_W-1:0]   out_setp_r, skid_setp_r;
  logic [rps_pkg::STATUS_W-1:0] out_status_r, skid_status_r;
  logic [rps_pkg::SETP_W-1:0]   res_setp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preheat_r  <= rps_pkg::RST_PREHEAT;
      soak_r     <= rps_pkg::RST_SOAK;
      soak_sec_r <= rps_pkg::RST_SOAK_SEC;
      rampup_r   <= rps_pkg::RST_RAMPUP;
      peak_sec_r <= rps_pkg::RST_PEAK_SEC;
      cooldown_r <= rps_pkg::RST_COOLDOWN;
      sps_r      <= rps_pkg::RST_SPS;
    end else if (cfg_we) begin
      case (cfg_index)
        rps_pkg::CFG_PREHEAT:  preheat_r  <= cfg_wdata[rps_pkg::DEG_W-1:0];
        rps_pkg::CFG_SOAK:     soak_r     <= cfg_wdata[rps_pkg::DEG_W-1:0];
        rps_pkg::CFG_SOAK_SEC: soak_sec_r <= cfg_wdata[rps_pkg::SEC_W-1:0];
        rps_pkg::CFG_RAMPUP:   rampup_r   <= cfg_wdata[rps_pkg::DEG_W-1:0];
        rps_pkg::CFG_PEAK_SEC: peak_sec_r <= cfg_wdata[rps_pkg::SEC_W-1:0];
        rps_pkg::CFG_COOLDOWN: cooldown_r <= cfg_wdata[rps_pkg::DEG_W-1:0];
        rps_pkg::CFG_SPS:      sps_r      <= cfg_wdata[rps_pkg::SPS_W-1:0];
        default: ;
      endcase
    end
  end

  // whole degrees, truncated toward zero
  assign t_int    = in_temperature[rps_pkg::TEMP_W-1:2]
                  + rps_pkg::TI_W'(in_temperature[rps_pkg::TEMP_W-1] &&
                                   (in_temperature[1:0] != 2'b00));
  assign t_ext    = $signed({t_int[rps_pkg::TI_W-1], t_int});
  assign cool_ext = $signed({{(rps_pkg::DIFF_W - rps_pkg::DEG_W){1'b0}}, cooldown_r});
  assign hot      = t_ext > cool_ext;

  always_comb begin
    case (phase_r)
      rps_pkg::PH_PREHEAT: target = preheat_r;
      rps_pkg::PH_RAMPUP:  target = rampup_r;
      default:             target = cooldown_r;
    endcase
  end

  assign win_diff = $signed({{(rps_pkg::DIFF_W - rps_pkg::DEG_W){1'b0}}, target}) - t_ext;
  assign in_win   = (win_diff == rps_pkg::DIFF_W'(0)) || (win_diff == rps_pkg::DIFF_W'(1))
                 || (win_diff == {rps_pkg::DIFF_W{1'b1}});

  assign sum       = {1'b0, acc_r} + {1'b0, step_r};
  assign soak_diff = (soak_r > preheat_r) ? (soak_r - preheat_r) : '0;
  assign prod      = rps_pkg::DIVR_W'(soak_sec_r) * rps_pkg::DIVR_W'(sps_r);

  // restoring divider, one quotient bit per cycle
  assign trial      = {rem_r, quo_r[rps_pkg::ACC_W-1]};
  assign trial_diff = trial - {1'b0, divisor_r};

  always_comb begin
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    divisor_nxt = divisor_r;
    if (cmd.div_start) begin
      quo_nxt     = {soak_diff, {rps_pkg::FRAC_BITS{1'b0}}};
      rem_nxt     = '0;
      divisor_nxt = (prod == '0) ? rps_pkg::DIVR_W'(1) : prod;
    end else if (cmd.div_step) begin
      if (!trial_diff[rps_pkg::DIVR_W]) begin
        rem_nxt = trial_diff[rps_pkg::DIVR_W-1:0];
        quo_nxt = {quo_r[rps_pkg::ACC_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[rps_pkg::DIVR_W-1:0];
        quo_nxt = {quo_r[rps_pkg::ACC_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    acc_nxt        = acc_r;
    step_nxt       = step_r;
    secs_nxt       = secs_r;
    res_status     = rps_pkg::ST_IGNORED;
    sts.soak_entry = 1'b0;
    if (cmd.step) begin
      case (in_operation)
        rps_pkg::OP_START: begin
          if (phase_r == rps_pkg::PH_RESET) begin
            if (!in_read_ok) begin
              res_status = rps_pkg::ST_RD_ERR;
            end else if (hot) begin
              res_status = rps_pkg::ST_HOT;
            end else begin
              phase_nxt  = rps_pkg::PH_PREHEAT;
              acc_nxt    = {preheat_r, {rps_pkg::FRAC_BITS{1'b0}}};
              res_status = rps_pkg::ST_TRANSITION;
            end
          end
        end
        rps_pkg::OP_STOP: begin
          if (phase_r != rps_pkg::PH_RESET) begin
            phase_nxt  = rps_pkg::PH_RESET;
            res_status = rps_pkg::ST_TRANSITION;
          end
        end
        rps_pkg::OP_SAMPLE: begin
          if (phase_r != rps_pkg::PH_RESET) begin
            if (!in_read_ok) begin
              phase_nxt  = rps_pkg::PH_RESET;
              res_status = rps_pkg::ST_RD_ERR;
            end else if (phase_r inside {rps_pkg::PH_SOAK, rps_pkg::PH_PEAK}) begin
              acc_nxt    = sum[rps_pkg::ACC_W] ? {rps_pkg::ACC_W{1'b1}}
                                               : sum[rps_pkg::ACC_W-1:0];
              res_status = rps_pkg::ST_HANDLED;
            end else if (in_win) begin
              res_status = rps_pkg::ST_TRANSITION;
              case (phase_r)
                rps_pkg::PH_PREHEAT: begin
                  phase_nxt      = rps_pkg::PH_SOAK;
                  secs_nxt       = soak_sec_r;
                  sts.soak_entry = 1'b1;
                end
                rps_pkg::PH_RAMPUP: begin
                  phase_nxt = rps_pkg::PH_PEAK;
                  step_nxt  = '0;
                  secs_nxt  = peak_sec_r;
                end
                default: begin
                  phase_nxt = rps_pkg::PH_RESET;
                end
              endcase
            end else begin
              res_status = rps_pkg::ST_HANDLED;
            end
          end
        end
        rps_pkg::OP_TICK: begin
          if (phase_r inside {rps_pkg::PH_SOAK, rps_pkg::PH_PEAK}) begin
            if (secs_r <= rps_pkg::SEC_W'(1)) begin
              secs_nxt   = '0;
              res_status = rps_pkg::ST_TRANSITION;
              if (phase_r == rps_pkg::PH_SOAK) begin
                phase_nxt = rps_pkg::PH_RAMPUP;
                acc_nxt   = {rampup_r, {rps_pkg::FRAC_BITS{1'b0}}};
              end else begin
                phase_nxt = rps_pkg::PH_COOLDOWN;
                acc_nxt   = {cooldown_r, {rps_pkg::FRAC_BITS{1'b0}}};
              end
            end else begin
              secs_nxt   = secs_r - 1'b1;
              res_status = rps_pkg::ST_HANDLED;
            end
          end
        end
        default: ;
      endcase
    end
    if (cmd.div_last) begin
      step_nxt = quo_nxt;
    end
  end

  assign res_setp = acc_nxt[rps_pkg::FRAC_BITS+rps_pkg::DEG_W-1 -: rps_pkg::SETP_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rps_pkg::PH_RESET;
      acc_r   <= '0;
      step_r  <= '0;
      secs_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      step_r  <= step_nxt;
      secs_r  <= secs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    divisor_r <= divisor_nxt;
    if (cmd.load_skid) begin
      skid_phase_r  <= phase_nxt;
      skid_setp_r   <= res_setp;
      skid_status_r <= res_status;
    end
    if (cmd.load_out) begin
      out_phase_r  <= phase_nxt;
      out_setp_r   <= res_setp;
      out_status_r <= res_status;
    end else if (cmd.move_skid) begin
      out_phase_r  <= skid_phase_r;
      out_setp_r   <= skid_setp_r;
      out_status_r <= skid_status_r;
    end
  end

  assign out_phase         = out_phase_r;
  assign out_setpoint      = out_setp_r;
  assign out_heater_enable = (out_phase_r != rps_pkg::PH_RESET);
  assign out_status        = out_status_r;

endmodule

### src/reflow_profile_sequencer.sv
`timescale 1ns / 1ps
// A result beat is registered in the output or, if it stalls, the skid register
// when its input beat is taken. Throughput: one beat per cycle while the skid
// register is empty; entering soak starts a serial divide (one quotient bit a
// cycle, 10 + FRAC_BITS steps) during which input is held off. A two-deep output
// stage keeps input flowing while a result waits. Reset: synchronous, active-low
// rst_n; phase returns to reset, state clears, registers load their defaults.
module reflow_profile_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  rps_in_if.sink                          in_ch,
  rps_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [rps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rps_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  rps_pkg::cmd_t cmd;
  rps_pkg::sts_t sts;

  rps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  rps_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_operation      (in_ch.operation),
    .in_temperature    (in_ch.temperature),
    .in_read_ok        (in_ch.read_ok),
    .cmd               (cmd),
    .sts               (sts),
    .out_phase         (out_ch.phase),
    .out_setpoint      (out_ch.setpoint),
    .out_heater_enable (out_ch.heater_enable),
    .out_status        (out_ch.status)
  );

endmodule

### src/rps_chk.sv
`timescale 1ns / 1ps
`include "reflow_profile_sequencer_macros.svh"

module rps_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [rps_pkg::PHASE_W-1:0]    out_phase,
  input logic                           out_heater_enable,
  input logic [rps_pkg::STATUS_W-1:0]   out_status
);

  `RPS_ASSERT_IMP(a_heater_phase, out_valid, out_heater_enable == (out_phase != rps_pkg::PH_RESET), "heater enable disagrees with phase")
  `RPS_ASSERT_IMP(a_phase_range, out_valid, out_phase <= rps_pkg::PH_COOLDOWN, "phase out of range")
  `RPS_ASSERT_IMP(a_refused_idle, out_valid && (out_status == rps_pkg::ST_HOT || out_status == rps_pkg::ST_RD_ERR), out_phase == rps_pkg::PH_RESET, "refusal or read error left an active phase")
  `RPS_ASSERT_NXT(a_beat_yields_result, in_valid && in_ready, out_valid, "accepted beat produced no result")
  `RPS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_phase) && $stable(out_status), "stalled result beat changed")

endmodule

bind reflow_profile_sequencer rps_chk u_rps_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_phase         (out_ch.phase),
  .out_heater_enable (out_ch.heater_enable),
  .out_status        (out_ch.status)
);
